@@ design/biae_pkg.sv @@
package biae_pkg;

	localparam int CAPACITY_WORDS_DEF = 256;
	localparam int WORD_W = 32;
	localparam int STEP_W = 5;

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_SEARCH = 3'd3;
	localparam logic [2:0] OP_GET    = 3'd4;
	localparam logic [2:0] OP_MAX    = 3'd5;
	localparam logic [2:0] OP_MIN    = 3'd6;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_FULL,
		C_POS_GE_CNT,
		C_EMPTY,
		C_IDX_GE_CNT,
		C_IDX_LE_POS,
		C_IDX1_GE_CNT,
		C_NO_MATCH
	} cond_t;

	typedef enum logic [1:0] {
		RA_IDX,
		RA_IDX_M1,
		RA_IDX_P1
	} rd_sel_t;

	typedef enum logic {
		WD_WORD,
		WD_RDATA
	} wd_sel_t;

	typedef enum logic [2:0] {
		IX_HOLD,
		IX_ZERO,
		IX_POS,
		IX_COUNT,
		IX_INC,
		IX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		AC_HOLD,
		AC_LOAD,
		AC_TAKE
	} acc_op_t;

	typedef enum logic [1:0] {
		CN_HOLD,
		CN_INC,
		CN_DEC
	} cnt_op_t;

	typedef struct packed {
		cond_t   cond;
		step_t   target;
		rd_sel_t rd;
		logic    we;
		wd_sel_t wd;
		idx_op_t idx;
		acc_op_t acc;
		cnt_op_t cnt;
		logic    set_ok;
		logic    set_found;
		logic    fin;
	} uword_t;

	localparam step_t U_END = 5'd0;
	localparam step_t U_A0  = 5'd1;
	localparam step_t U_A1  = 5'd2;
	localparam step_t U_I0  = 5'd3;
	localparam step_t U_I1  = 5'd4;
	localparam step_t U_I2  = 5'd5;
	localparam step_t U_I3  = 5'd6;
	localparam step_t U_I4  = 5'd7;
	localparam step_t U_D0  = 5'd8;
	localparam step_t U_D1  = 5'd9;
	localparam step_t U_D2  = 5'd10;
	localparam step_t U_D3  = 5'd11;
	localparam step_t U_S0  = 5'd12;
	localparam step_t U_S1  = 5'd13;
	localparam step_t U_S2  = 5'd14;
	localparam step_t U_S3  = 5'd15;
	localparam step_t U_G0  = 5'd16;
	localparam step_t U_G1  = 5'd17;
	localparam step_t U_G2  = 5'd18;
	localparam step_t U_M0  = 5'd19;
	localparam step_t U_M1  = 5'd20;
	localparam step_t U_M2  = 5'd21;
	localparam step_t U_M3  = 5'd22;
	localparam step_t U_M4  = 5'd23;

	function automatic step_t entry_step(logic [2:0] op);
		step_t s;
		unique case (op)
			OP_APPEND: s = U_A0;
			OP_INSERT: s = U_I0;
			OP_DELETE: s = U_D0;
			OP_SEARCH: s = U_S0;
			OP_GET:    s = U_G0;
			OP_MAX, OP_MIN: s = U_M0;
			default:   s = U_END;
		endcase
		return s;
	endfunction

	function automatic uword_t ucode(step_t s);
		uword_t w;
		w.cond      = C_NEXT;
		w.target    = U_END;
		w.rd        = RA_IDX;
		w.we        = 1'b0;
		w.wd        = WD_WORD;
		w.idx       = IX_HOLD;
		w.acc       = AC_HOLD;
		w.cnt       = CN_HOLD;
		w.set_ok    = 1'b0;
		w.set_found = 1'b0;
		w.fin       = 1'b0;
		unique case (s)
			U_END: begin
				w.fin = 1'b1;
			end
			U_A0: begin
				w.cond = C_FULL;
				w.idx  = IX_COUNT;
			end
			U_A1: begin
				w.we     = 1'b1;
				w.cnt    = CN_INC;
				w.set_ok = 1'b1;
				w.cond   = C_ALWAYS;
			end
			U_I0: begin
				w.cond = C_FULL;
				w.idx  = IX_COUNT;
			end
			U_I1: begin
				w.cond = C_POS_GE_CNT;
			end
			U_I2: begin
				w.cond   = C_IDX_LE_POS;
				w.target = U_I4;
				w.rd     = RA_IDX_M1;
			end
			U_I3: begin
				w.we     = 1'b1;
				w.wd     = WD_RDATA;
				w.idx    = IX_DEC;
				w.cond   = C_ALWAYS;
				w.target = U_I2;
			end
			U_I4: begin
				w.we     = 1'b1;
				w.cnt    = CN_INC;
				w.set_ok = 1'b1;
				w.cond   = C_ALWAYS;
			end
			U_D0: begin
				w.cond = C_POS_GE_CNT;
				w.idx  = IX_POS;
			end
			U_D1: begin
				w.cond   = C_IDX1_GE_CNT;
				w.target = U_D3;
				w.rd     = RA_IDX_P1;
			end
			U_D2: begin
				w.we     = 1'b1;
				w.wd     = WD_RDATA;
				w.idx    = IX_INC;
				w.cond   = C_ALWAYS;
				w.target = U_D1;
			end
			U_D3: begin
				w.cnt    = CN_DEC;
				w.set_ok = 1'b1;
				w.cond   = C_ALWAYS;
			end
			U_S0: begin
				w.idx = IX_ZERO;
			end
			U_S1: begin
				w.cond = C_IDX_GE_CNT;
			end
			U_S2: begin
				w.idx    = IX_INC;
				w.cond   = C_NO_MATCH;
				w.target = U_S1;
			end
			U_S3: begin
				w.set_ok    = 1'b1;
				w.set_found = 1'b1;
				w.cond      = C_ALWAYS;
			end
			U_G0: begin
				w.cond = C_POS_GE_CNT;
				w.idx  = IX_POS;
			end
			U_G1: begin
				w.rd = RA_IDX;
			end
			U_G2: begin
				w.acc    = AC_LOAD;
				w.set_ok = 1'b1;
				w.cond   = C_ALWAYS;
			end
			U_M0: begin
				w.cond = C_EMPTY;
				w.idx  = IX_ZERO;
			end
			U_M1: begin
				w.idx = IX_INC;
			end
			U_M2: begin
				w.acc    = AC_LOAD;
				w.set_ok = 1'b1;
			end
			U_M3: begin
				w.cond = C_IDX_GE_CNT;
			end
			U_M4: begin
				w.acc    = AC_TAKE;
				w.idx    = IX_INC;
				w.cond   = C_ALWAYS;
				w.target = U_M3;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

@@ design/bounded_int_array_engine.sv @@
// Ordered store of signed 32-bit words with a fixed capacity, driven by a small microcoded
// sequencer over an entry RAM with one write port and one registered read port. One transaction
// is taken only while the sequencer is idle, and its result sits in an output register, so the
// next transaction may be taken while a result still waits. Each operation runs from the accept
// step through its microcode steps to the step that loads the result register; insert and delete
// loop once for each entry moved, and search, max and min once for each entry visited, with each
// RAM read needing an address step and a data step. Failed requests end after their checks. While
// an earlier result has not been taken, the sequencer holds at its last step and the input stays
// blocked.
module bounded_int_array_engine #(
	parameter int CAPACITY_WORDS = biae_pkg::CAPACITY_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  position,
	input  logic signed [31:0] operand_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        success,
	output logic signed [31:0] result_value,
	output logic [7:0]  found_position,
	output logic [8:0]  entry_count
);

	import biae_pkg::*;

	localparam int AW   = $clog2(CAPACITY_WORDS);
	localparam int CW   = $clog2(CAPACITY_WORDS + 1);
	localparam int IW   = CW + 1;
	localparam int CMPW = (CW > 8) ? CW : 8;
	localparam int OW   = (CW > 9) ? CW : 9;

	seq_state_t state_q, state_d;
	step_t      upc_q, upc_d;
	uword_t     uw;
	logic       cond_true;
	logic       run_step;
	logic       load_out;
	logic       in_fire;

	logic [2:0]        func_q;
	logic [7:0]        pos_q;
	logic [WORD_W-1:0] word_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [WORD_W-1:0] acc_q;
	logic              ok_q;
	logic [7:0]        found_q;

	logic              out_valid_q;
	logic              success_q;
	logic [WORD_W-1:0] result_value_q;
	logic [7:0]        found_position_q;
	logic [8:0]        entry_count_q;

	logic [CMPW-1:0]   cnt_x, pos_x, idx_x, idx_m1_x;
	logic [CW-1:0]     idx_m1;
	logic [IW-1:0]     idx_p1;
	logic [OW-1:0]     count_ext;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;
	logic              take;

	assign uw       = ucode(upc_q);
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign cnt_x     = CMPW'(count_q);
	assign pos_x     = CMPW'(pos_q);
	assign idx_x     = CMPW'(idx_q);
	assign idx_m1    = idx_q - CW'(1);
	assign idx_m1_x  = CMPW'(idx_m1);
	assign idx_p1    = IW'(idx_q) + IW'(1);
	assign count_ext = OW'(count_q);

	always_comb begin
		case (uw.cond)
			C_NEXT:        cond_true = 1'b0;
			C_ALWAYS:      cond_true = 1'b1;
			C_FULL:        cond_true = (count_q == CW'(CAPACITY_WORDS));
			C_POS_GE_CNT:  cond_true = (pos_x >= cnt_x);
			C_EMPTY:       cond_true = (count_q == '0);
			C_IDX_GE_CNT:  cond_true = (idx_q >= count_q);
			C_IDX_LE_POS:  cond_true = (idx_x <= pos_x);
			C_IDX1_GE_CNT: cond_true = (idx_p1 >= IW'(count_q));
			C_NO_MATCH:    cond_true = (ram_rdata != word_q);
			default:       cond_true = 1'b0;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		upc_d    = upc_q;
		run_step = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RUN;
					upc_d   = entry_step(func);
				end
			end
			ST_RUN: begin
				if (uw.fin) begin
					if (!out_valid_q || out_ready) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					run_step = 1'b1;
					upc_d    = cond_true ? uw.target : step_t'(upc_q + step_t'(1));
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			upc_q   <= U_END;
		end else begin
			state_q <= state_d;
			upc_q   <= upc_d;
		end
	end

	always_comb begin
		case (uw.rd)
			RA_IDX_M1: ram_raddr = idx_m1[AW-1:0];
			RA_IDX_P1: ram_raddr = idx_p1[AW-1:0];
			default:   ram_raddr = idx_q[AW-1:0];
		endcase
	end

	assign ram_we    = run_step && uw.we;
	assign ram_waddr = idx_q[AW-1:0];
	assign ram_wdata = (uw.wd == WD_RDATA) ? ram_rdata : word_q;

	biae_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CAPACITY_WORDS)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign take = (func_q == OP_MAX) ? ($signed(ram_rdata) > $signed(acc_q))
	                                 : ($signed(ram_rdata) < $signed(acc_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (run_step) begin
			case (uw.cnt)
				CN_INC:  count_q <= count_q + CW'(1);
				CN_DEC:  count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q  <= func;
			pos_q   <= position;
			word_q  <= operand_value;
			acc_q   <= '0;
			ok_q    <= 1'b0;
			found_q <= '0;
		end else if (run_step) begin
			case (uw.idx)
				IX_ZERO:  idx_q <= '0;
				IX_POS:   idx_q <= pos_x[CW-1:0];
				IX_COUNT: idx_q <= count_q;
				IX_INC:   idx_q <= idx_p1[CW-1:0];
				IX_DEC:   idx_q <= idx_m1;
				default:  idx_q <= idx_q;
			endcase
			case (uw.acc)
				AC_LOAD: acc_q <= ram_rdata;
				AC_TAKE: acc_q <= take ? ram_rdata : acc_q;
				default: acc_q <= acc_q;
			endcase
			if (uw.set_ok) begin
				ok_q <= 1'b1;
			end
			if (uw.set_found) begin
				found_q <= idx_m1_x[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			success_q        <= ok_q;
			result_value_q   <= acc_q;
			found_position_q <= found_q;
			entry_count_q    <= count_ext[8:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign success        = success_q;
	assign result_value   = result_value_q;
	assign found_position = found_position_q;
	assign entry_count    = entry_count_q;

endmodule

@@ design/biae_ram.sv @@
module biae_ram #(
	parameter int WIDTH = biae_pkg::WORD_W,
	parameter int DEPTH = biae_pkg::CAPACITY_WORDS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ tb/sv/store_result_check.sv @@
module store_result_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         func,
	input  logic [7:0]         position,
	input  logic signed [31:0] operand_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               success,
	input  logic signed [31:0] result_value,
	input  logic [7:0]         found_position,
	input  logic [8:0]         entry_count,
	output int                 mismatch_count,
	output int                 pending_count,
	output int                 model_count,
	output int                 results_checked
);

	import biae_pkg::*;

	localparam int CAP = CAPACITY_WORDS_DEF;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] value;
		logic [7:0]         found;
		logic [8:0]         count;
	} store_result_t;

	logic signed [31:0] words [CAP];
	int                 stored;
	store_result_t      expected_results [$];
	store_result_t      oldest;
	store_result_t      observed;

	function automatic store_result_t apply_request(
		input logic [2:0]         f,
		input logic [7:0]         p,
		input logic signed [31:0] w
	);
		store_result_t      r;
		logic signed [31:0] best;
		int                 i;
		r = '0;
		best = '0;
		case (f)
			OP_APPEND: begin
				if (stored < CAP) begin
					words[stored] = w;
					stored++;
					r.ok = 1'b1;
				end
			end
			OP_INSERT: begin
				if (p < stored && stored < CAP) begin
					for (i = stored; i > p; i--)
						words[i] = words[i-1];
					words[p] = w;
					stored++;
					r.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (p < stored) begin
					for (i = p; i + 1 < stored; i++)
						words[i] = words[i+1];
					stored--;
					r.ok = 1'b1;
				end
			end
			OP_SEARCH: begin
				for (i = 0; i < stored && !r.ok; i++) begin
					if (words[i] == w) begin
						r.found = i[7:0];
						r.ok = 1'b1;
					end
				end
			end
			OP_GET: begin
				if (p < stored) begin
					r.value = words[p];
					r.ok = 1'b1;
				end
			end
			OP_MAX, OP_MIN: begin
				if (stored > 0) begin
					best = words[0];
					for (i = 1; i < stored; i++) begin
						if (f == OP_MAX ? (words[i] > best) : (words[i] < best))
							best = words[i];
					end
					r.value = best;
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.count = stored[8:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored = 0;
			expected_results.delete();
			mismatch_count = 0;
			pending_count = 0;
			model_count = 0;
			results_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				observed.ok = success;
				observed.value = result_value;
				observed.found = found_position;
				observed.count = entry_count;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with no request waiting: ok=%0b value=%h found=%0d count=%0d",
							$realtime, observed.ok, observed.value, observed.found,
							observed.count);
				end else begin
					oldest = expected_results.pop_front();
					results_checked++;
					if (observed.ok !== oldest.ok || observed.value !== oldest.value ||
						observed.found !== oldest.found || observed.count !== oldest.count) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: result mismatch: expected ok=%0b value=%h found=%0d count=%0d, got ok=%0b value=%h found=%0d count=%0d",
								$realtime, oldest.ok, oldest.value, oldest.found, oldest.count,
								observed.ok, observed.value, observed.found, observed.count);
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(apply_request(func, position, operand_value));
			pending_count = expected_results.size();
			model_count = stored;
		end
	end

endmodule

@@ tb/sv/tb.sv @@
module tb;

	import biae_pkg::*;

	localparam int          CAP = CAPACITY_WORDS_DEF;
	localparam logic [2:0]  OP_UNUSED = 3'd7;
	localparam int          HOLD_CYCLES = 300;
	localparam int          STALL_LIMIT = 5000;
	localparam int          DRAIN_CYCLES = 20;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         func;
	logic [7:0]         position;
	logic signed [31:0] operand_value;
	logic               out_valid;
	logic               out_ready;
	logic               success;
	logic signed [31:0] result_value;
	logic [7:0]         found_position;
	logic [8:0]         entry_count;

	int mismatch_count;
	int pending_count;
	int model_count;
	int results_checked;
	int items_sent;
	bit tx_gaps;
	bit rx_gaps;
	bit hold_request;

	bounded_int_array_engine i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.position       (position),
		.operand_value  (operand_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.success        (success),
		.result_value   (result_value),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	store_result_check i_result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.position        (position),
		.operand_value   (operand_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.success         (success),
		.result_value    (result_value),
		.found_position  (found_position),
		.entry_count     (entry_count),
		.mismatch_count  (mismatch_count),
		.pending_count   (pending_count),
		.model_count     (model_count),
		.results_checked (results_checked)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic send_request(input logic [2:0] f, input logic [7:0] p, input logic [31:0] v);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		func = f;
		position = p;
		operand_value = v;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic pick_random_request(
		output logic [2:0]  f,
		output logic [7:0]  p,
		output logic [31:0] v
	);
		int roll;
		roll = $urandom_range(0, 99);
		if (model_count > 0 && $urandom_range(0, 9) != 0)
			p = 8'($urandom_range(0, model_count - 1));
		else
			p = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 7))
				0: v = 32'h8000_0000;
				1: v = 32'h7fff_ffff;
				2: v = 32'h0000_0000;
				3: v = 32'hffff_ffff;
				4: v = 32'h0000_0001;
				5: v = 32'h8000_0001;
				6: v = 32'h7fff_fffe;
				default: v = 32'h0000_00ff;
			endcase
		end else begin
			v = $urandom;
		end
		if (roll < 27)
			f = OP_APPEND;
		else if (roll < 42)
			f = OP_INSERT;
		else if (roll < 57)
			f = OP_DELETE;
		else if (roll < 70)
			f = OP_SEARCH;
		else if (roll < 82)
			f = OP_GET;
		else if (roll < 90)
			f = OP_MAX;
		else if (roll < 98)
			f = OP_MIN;
		else
			f = OP_UNUSED;
	endtask

	initial begin : result_sink
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		logic [2:0]  f;
		logic [7:0]  p;
		logic [31:0] v;
		logic [31:0] tag_base;
		int          tags;
		int          n;
		in_valid = 1'b0;
		func = OP_APPEND;
		position = '0;
		operand_value = '0;
		arst_n = 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		hold_request = 1'b0;
		items_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty store: every operation that needs an entry fails; then directed requests run on a small store.
		send_request(OP_MAX, 8'd0, 32'h0);
		send_request(OP_MIN, 8'd0, 32'h0);
		send_request(OP_GET, 8'd0, 32'h0);
		send_request(OP_DELETE, 8'd0, 32'h0);
		send_request(OP_INSERT, 8'd0, 32'h1);
		send_request(OP_SEARCH, 8'd0, 32'h0);
		send_request(OP_UNUSED, 8'd0, 32'h0);
		send_request(OP_APPEND, 8'd0, 32'h8000_0000);
		send_request(OP_APPEND, 8'd255, 32'h7fff_ffff);
		send_request(OP_APPEND, 8'd0, 32'h0);
		send_request(OP_APPEND, 8'd0, 32'h0);
		send_request(OP_INSERT, 8'd0, 32'h5);
		send_request(OP_INSERT, 8'd4, 32'h1234_5678);
		send_request(OP_INSERT, 8'd6, 32'hffff_ffff);
		send_request(OP_GET, 8'd5, 32'h0);
		send_request(OP_GET, 8'd6, 32'h0);
		send_request(OP_GET, 8'd255, 32'h0);
		send_request(OP_SEARCH, 8'd0, 32'h7fff_ffff);
		send_request(OP_SEARCH, 8'd0, 32'h0);
		send_request(OP_MAX, 8'd0, 32'h0);
		send_request(OP_MIN, 8'd0, 32'h0);
		send_request(OP_DELETE, 8'd5, 32'h0);
		send_request(OP_DELETE, 8'd0, 32'h0);
		send_request(OP_UNUSED, 8'd255, 32'hffff_ffff);
		send_request(OP_DELETE, 8'd10, 32'h0);

		for (n = 0; n < 80; n++) begin
			if (n == 40)
				hold_request = 1'b1;
			pick_random_request(f, p, v);
			send_request(f, p, v);
		end

		in_valid = 1'b0;
		wait (pending_count == 0);
		@(negedge clk);

		// Fill with a known ramp so later searches can land at high positions.
		tag_base = $urandom;
		tags = 0;
		while (model_count < CAP) begin
			send_request(OP_APPEND, 8'($urandom_range(0, 255)), tag_base + tags);
			tags++;
		end
		send_request(OP_APPEND, 8'($urandom_range(0, 255)), $urandom);
		send_request(OP_INSERT, 8'($urandom_range(0, 255)), $urandom);
		send_request(OP_GET, 8'd255, 32'h0);
		for (n = 0; n < 20; n++) begin
			case ($urandom_range(0, 4))
				0, 1: send_request(OP_SEARCH, 8'($urandom_range(0, 255)),
					tag_base + $urandom_range(tags / 2, tags - 1));
				2: send_request(OP_GET, 8'($urandom_range(0, 255)), $urandom);
				3: send_request($urandom_range(0, 1) ? OP_MAX : OP_MIN,
					8'($urandom_range(0, 255)), $urandom);
				default: send_request(OP_INSERT, 8'($urandom_range(0, 255)), $urandom);
			endcase
		end
		send_request(OP_DELETE, 8'd255, 32'h0);
		send_request(OP_INSERT, 8'd254, $urandom);
		send_request(OP_SEARCH, 8'd0, $urandom);

		for (n = 0; n < 60; n++) begin
			pick_random_request(f, p, v);
			send_request(f, p, v);
		end

		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		for (n = 0; n < 40; n++) begin
			pick_random_request(f, p, v);
			send_request(f, p, v);
		end

		in_valid = 1'b0;
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests covering all operations and the unused selector, %0d results checked.",
			items_sent, results_checked);
		$display("The store was filled to capacity and the output was held off for %0d cycles once.",
			HOLD_CYCLES);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
